### design/npba_pkg.sv
// shared types and constants of the port bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

package npba_pkg;

    localparam int KIND_W  = 2;
    localparam int START_W = 11;
    localparam int PORT_W  = 16;
    localparam int STAT_W  = 2;
    localparam int MAP_W   = 32;
    localparam int BIT_W   = 5;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TAKEN = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic red_step;
        logic rd_issue;
        logic next_word;
        logic finish;
        logic fin_err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_clr;
        logic red_done;
        logic is_alloc;
        logic bad;
        logic word_full;
        logic last_try;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### design/npba_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module npba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2016,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/npba_ctrl.sv
// controller state machine of the port bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

module npba_ctrl
    import npba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.last_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                priority if (i_sts.bad) begin
                    if (i_sts.out_free) begin
                        o_cmd.fin_err = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (i_sts.is_alloc && !i_sts.red_done) begin
                    o_cmd.red_step = 1'b1;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // full word: walk down to the next one unless all were tried
                priority if (i_sts.is_alloc && i_sts.word_full && !i_sts.last_try) begin
                    o_cmd.next_word = 1'b1;
                    n_state         = ST_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    // output register still held by the receiver
                    n_state = ST_EVAL;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### design/npba_dp.sv
// datapath of the port bitmap allocator: request registers, bitmap ram, result word
`timescale 1ns / 1ps
`default_nettype none

module npba_dp
    import npba_pkg::*;
#(
    parameter int MAP_WORDS = 2016,
    parameter int BASE_PORT = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [START_W-1:0]  i_start_word,
    input  wire logic [PORT_W-1:0]   i_port_number,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [STAT_W-1:0]   o_status,
    output logic      [PORT_W-1:0]   o_granted_port
);

    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int RED_Q     = ((1 << START_W) - 1) / MAP_WORDS;
    localparam int RED_STEPS = $clog2(RED_Q + 1);
    localparam int RED_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    localparam logic [START_W-1:0] LAST_WORD = START_W'(MAP_WORDS - 1);

    // one restoring step of start_word mod MAP_WORDS
    function automatic logic [START_W-1:0] red_one(
        input logic [START_W-1:0] v,
        input logic [RED_W-1:0]   k
    );
        logic [START_W:0] d;
        d = (START_W+1)'(MAP_WORDS) << k;
        if ({1'b0, v} >= d) begin
            return START_W'({1'b0, v} - d);
        end
        return v;
    endfunction

    logic [START_W-1:0] r_idx;
    logic [START_W-1:0] r_tried;
    logic [RED_W-1:0]   r_red_left;
    logic [KIND_W-1:0]  r_kind;
    logic [PORT_W-1:0]  r_port;
    logic [BIT_W-1:0]   r_bit;
    logic               r_bad;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [PORT_W-1:0]  r_granted;

    logic [PORT_W:0]    in_off;
    logic               in_below;
    logic               in_bad;
    logic [MAP_W-1:0]   rd_data;
    logic [BIT_W-1:0]   low_bit;
    logic [MAP_W-1:0]   mask;
    logic               fin_we;
    logic [MAP_W-1:0]   fin_data;
    logic [STAT_W-1:0]  fin_status;
    logic [PORT_W-1:0]  fin_port;
    logic [PORT_W+1:0]  alloc_sum;
    logic               ram_we;
    logic [MAP_W-1:0]   ram_wdata;
    logic               out_free;

    // request decode at accept
    assign in_off   = {1'b0, i_port_number} - (PORT_W+1)'(BASE_PORT);
    assign in_below = i_port_number < PORT_W'(BASE_PORT);
    always_comb begin
        in_bad = 1'b0;
        if (i_kind != KIND_ALLOC) begin
            in_bad = (i_kind != KIND_TAKE && i_kind != KIND_RELEASE) || in_below ||
                     (in_off[PORT_W-1:BIT_W] >= START_W'(MAP_WORDS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_idx <= r_idx + START_W'(1);
            end else if (i_cmd.accept) begin
                if (i_kind == KIND_ALLOC) begin
                    r_idx <= red_one(i_start_word, RED_W'(RED_STEPS - 1));
                end else begin
                    r_idx <= in_off[PORT_W-1:BIT_W];
                end
            end else if (i_cmd.red_step) begin
                r_idx <= red_one(r_idx, r_red_left - RED_W'(1));
            end else if (i_cmd.next_word) begin
                r_idx <= (r_idx == '0) ? LAST_WORD : r_idx - START_W'(1);
            end
            if (i_cmd.finish || i_cmd.fin_err) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind     <= i_kind;
            r_port     <= i_port_number;
            r_bit      <= in_off[BIT_W-1:0];
            r_bad      <= in_bad;
            r_tried    <= '0;
            r_red_left <= RED_W'(RED_STEPS - 1);
        end else begin
            if (i_cmd.red_step) begin
                r_red_left <= r_red_left - RED_W'(1);
            end
            if (i_cmd.next_word) begin
                r_tried <= r_tried + START_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_status  <= fin_status;
            r_granted <= fin_port;
        end else if (i_cmd.fin_err) begin
            r_status  <= STAT_RANGE;
            r_granted <= '0;
        end
    end

    // lowest clear bit of the word just read
    always_comb begin
        low_bit = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (!rd_data[b]) begin
                low_bit = BIT_W'(b);
            end
        end
    end

    assign mask      = MAP_W'(1) << r_bit;
    assign alloc_sum = (PORT_W+2)'(BASE_PORT) + (PORT_W+2)'({r_idx, 5'b0}) +
                       (PORT_W+2)'(low_bit);

    always_comb begin
        fin_we     = 1'b0;
        fin_data   = rd_data;
        fin_status = STAT_RANGE;
        fin_port   = '0;
        unique case (r_kind)
            KIND_ALLOC: begin
                if (&rd_data) begin
                    fin_status = STAT_FULL;
                end else begin
                    fin_we     = 1'b1;
                    fin_data   = rd_data | (MAP_W'(1) << low_bit);
                    fin_status = STAT_OK;
                    fin_port   = alloc_sum[PORT_W-1:0];
                end
            end
            KIND_TAKE: begin
                if ((rd_data & mask) != '0) begin
                    fin_status = STAT_TAKEN;
                end else begin
                    fin_we     = 1'b1;
                    fin_data   = rd_data | mask;
                    fin_status = STAT_OK;
                    fin_port   = r_port;
                end
            end
            KIND_RELEASE: begin
                fin_we     = 1'b1;
                fin_data   = rd_data & ~mask;
                fin_status = STAT_OK;
                fin_port   = r_port;
            end
            default: begin
                fin_status = STAT_RANGE;
            end
        endcase
    end

    assign ram_we    = i_cmd.clr_step || (i_cmd.finish && fin_we);
    assign ram_wdata = i_cmd.clr_step ? '0 : fin_data;

    npba_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || i_ready;

    assign o_sts.last_clr  = (r_idx == LAST_WORD);
    assign o_sts.red_done  = (r_red_left == '0);
    assign o_sts.is_alloc  = (r_kind == KIND_ALLOC);
    assign o_sts.bad       = r_bad;
    assign o_sts.word_full = &rd_data;
    assign o_sts.last_try  = (r_tried == LAST_WORD);
    assign o_sts.out_free  = out_free;

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_port = r_granted;

endmodule

`default_nettype wire

### design/nat_port_bitmap_allocator.sv
// top level of the translation-port bitmap allocator
// Requests come in on the i_valid / o_ready channel (kind, start_word,
// port_number) and each gives exactly one result word on the o_valid /
// i_ready channel (status, granted_port).
// One request is worked at a time. A take, a release, or an allocate whose
// first word has a free bit passes the accept cycle, which latches and
// decodes it, the read state, which issues the registered read of the
// bitmap ram, and the evaluate state, which picks the bit, writes the word
// back and loads the result. o_valid rises as the block returns to idle
// with o_ready high again, so a new request is taken only after the last
// one's result is loaded.
// Each further full word walked by an allocate adds a read and a test step;
// reducing start_word modulo MAP_WORDS adds restoring steps (none by default).
// Malformed or out-of-map requests skip the read, bitmap untouched.
// The result sits in an output register; a stalled receiver holds the
// block at its last step until the register frees up, and o_ready stays
// low meanwhile.
// After reset the block clears the bitmap ram, one word a cycle, with
// o_ready low; every port is then free.
`timescale 1ns / 1ps
`default_nettype none

module nat_port_bitmap_allocator
    import npba_pkg::*;
#(
    parameter int MAP_WORDS = 2016,
    parameter int BASE_PORT = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [START_W-1:0] i_start_word,
    input  wire logic [PORT_W-1:0]  i_port_number,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [STAT_W-1:0]  o_status,
    output logic      [PORT_W-1:0]  o_granted_port
);

    t_cmd cmd;
    t_sts sts;

    npba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    npba_dp #(
        .MAP_WORDS (MAP_WORDS),
        .BASE_PORT (BASE_PORT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_start_word   (i_start_word),
        .i_port_number  (i_port_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_granted_port (o_granted_port)
    );

    // a failed request never reports a port
    a_fail_no_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_granted_port == '0))
        else $error("failed request carries a port");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish || cmd.fin_err) |-> sts.out_free)
        else $error("pending result overwritten");

    // no request taken while the bitmap is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> !o_ready)
        else $error("request accepted during clear pass");

    // a bitmap read is always followed by an evaluation, never another read
    a_read_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_issue |=> !cmd.rd_issue && !o_ready)
        else $error("bitmap read not evaluated");

endmodule

`default_nettype wire
